### hdl/lpf_pkg.sv
// ----------------------------------------------------------------------------
// lpf_pkg
// Shared types, codes and helpers for the link path failover block.
// ----------------------------------------------------------------------------
package lpf_pkg;

  // Counter and limit width, saturation value and reset value of the limits
  localparam int unsigned CNT_W = 8;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(3);

  // Configuration register indexes
  localparam int unsigned REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_DIRECT_FAIL_LIMIT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_RECOVERY_LIMIT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_RELAY_FAIL_LIMIT = 2'd2;

  // Stream widths
  localparam int unsigned S_TDATA_W = 8;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TDATA_W = 8;

  // Event kinds
  typedef enum logic [1:0] {
    CMD_DIRECT_RESULT  = 2'd0,
    CMD_RELAY_READY    = 2'd1,
    CMD_RELAY_RESULT   = 2'd2,
    CMD_RECOVERY_PROBE = 2'd3
  } lpf_cmd_e;

  // Path state machine, one-hot
  typedef enum logic [2:0] {
    PATH_DIRECT    = 3'b001,
    PATH_DISCOVERY = 3'b010,
    PATH_RELAY     = 3'b100
  } lpf_path_e;

  // Encoded path as reported on the result stream
  localparam logic [1:0] PCODE_DIRECT = 2'd0;
  localparam logic [1:0] PCODE_DISCOVERY = 2'd1;
  localparam logic [1:0] PCODE_RELAY = 2'd2;

  // Path and counter state
  typedef struct packed {
    lpf_path_e        path;
    logic [CNT_W-1:0] direct_fail_cnt;
    logic [CNT_W-1:0] relay_fail_cnt;
    logic [CNT_W-1:0] recovery_cnt;
  } lpf_state_t;

  // Policy registers seen by the update logic
  typedef struct packed {
    logic [CNT_W-1:0] direct_fail_limit;
    logic [CNT_W-1:0] recovery_limit;
    logic [CNT_W-1:0] relay_fail_limit;
    logic             policy_ok;
  } lpf_cfg_t;

  // Saturating increment
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

  // One-hot path to its reported code
  function automatic logic [1:0] path_encode(input lpf_path_e p);
    logic [1:0] code;
    unique case (p)
      PATH_DIRECT:    code = PCODE_DIRECT;
      PATH_DISCOVERY: code = PCODE_DISCOVERY;
      PATH_RELAY:     code = PCODE_RELAY;
      default:        code = PCODE_DIRECT;
    endcase
    return code;
  endfunction

endpackage

### hdl/lpf_cfg.sv
// ----------------------------------------------------------------------------
// lpf_cfg
// Policy limit registers with write decode and the policy valid check.
// ----------------------------------------------------------------------------
module lpf_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lpf_pkg::REG_IDX_W-1:0] cfg_addr_i,
  input  logic [lpf_pkg::CNT_W-1:0]     cfg_wdata_i,
  output lpf_pkg::lpf_cfg_t             cfg_o
);
  import lpf_pkg::*;

  logic [CNT_W-1:0] direct_fail_limit_q;
  logic [CNT_W-1:0] recovery_limit_q;
  logic [CNT_W-1:0] relay_fail_limit_q;

  // Decode writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direct_fail_limit_q <= LIMIT_RESET;
      recovery_limit_q    <= LIMIT_RESET;
      relay_fail_limit_q  <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_DIRECT_FAIL_LIMIT: direct_fail_limit_q <= cfg_wdata_i;
        REG_RECOVERY_LIMIT:    recovery_limit_q    <= cfg_wdata_i;
        REG_RELAY_FAIL_LIMIT:  relay_fail_limit_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // A zero limit makes the whole policy invalid
  always_comb begin
    cfg_o.direct_fail_limit = direct_fail_limit_q;
    cfg_o.recovery_limit    = recovery_limit_q;
    cfg_o.relay_fail_limit  = relay_fail_limit_q;
    cfg_o.policy_ok         = (direct_fail_limit_q != '0) && (recovery_limit_q != '0) &&
                              (relay_fail_limit_q != '0);
  end

endmodule

### hdl/lpf_step.sv
// ----------------------------------------------------------------------------
// lpf_step
// Next-state logic: applies one event to the path state and counters.
// ----------------------------------------------------------------------------
module lpf_step (
  input  lpf_pkg::lpf_state_t state_i,
  input  lpf_pkg::lpf_cfg_t   cfg_i,
  input  lpf_pkg::lpf_cmd_e   cmd_i,
  input  logic                success_i,
  output lpf_pkg::lpf_state_t state_o,
  output logic                error_o
);
  import lpf_pkg::*;

  logic [CNT_W-1:0] direct_inc;
  logic [CNT_W-1:0] relay_inc;
  logic [CNT_W-1:0] recovery_inc;

  assign direct_inc   = sat_inc(state_i.direct_fail_cnt);
  assign relay_inc    = sat_inc(state_i.relay_fail_cnt);
  assign recovery_inc = sat_inc(state_i.recovery_cnt);

  // Apply the event; an error leaves all state untouched
  always_comb begin
    state_o = state_i;
    error_o = 1'b0;
    if (!cfg_i.policy_ok) begin
      error_o = 1'b1;
    end else begin
      unique case (cmd_i)
        CMD_DIRECT_RESULT: begin
          if (state_i.path != PATH_DIRECT) begin
            error_o = 1'b1;
          end else if (success_i) begin
            state_o.direct_fail_cnt = '0;
          end else if (direct_inc >= cfg_i.direct_fail_limit) begin
            state_o.path            = PATH_DISCOVERY;
            state_o.direct_fail_cnt = '0;
          end else begin
            state_o.direct_fail_cnt = direct_inc;
          end
        end
        CMD_RELAY_READY: begin
          if (state_i.path != PATH_DISCOVERY) begin
            error_o = 1'b1;
          end else if (success_i) begin
            state_o.path           = PATH_RELAY;
            state_o.relay_fail_cnt = '0;
            state_o.recovery_cnt   = '0;
          end
        end
        CMD_RELAY_RESULT: begin
          if (state_i.path != PATH_RELAY) begin
            error_o = 1'b1;
          end else if (success_i) begin
            state_o.relay_fail_cnt = '0;
          end else if (relay_inc >= cfg_i.relay_fail_limit) begin
            state_o.path           = PATH_DISCOVERY;
            state_o.relay_fail_cnt = '0;
            state_o.recovery_cnt   = '0;
          end else begin
            state_o.relay_fail_cnt = relay_inc;
          end
        end
        CMD_RECOVERY_PROBE: begin
          if (state_i.path != PATH_RELAY && state_i.path != PATH_DISCOVERY) begin
            error_o = 1'b1;
          end else if (!success_i) begin
            state_o.recovery_cnt = '0;
          end else if (recovery_inc >= cfg_i.recovery_limit) begin
            state_o.path           = PATH_DIRECT;
            state_o.recovery_cnt   = '0;
            state_o.relay_fail_cnt = '0;
          end else begin
            state_o.recovery_cnt = recovery_inc;
          end
        end
        default: error_o = 1'b1;
      endcase
    end
  end

endmodule

### hdl/link_path_failover_fsm.sv
// ----------------------------------------------------------------------------
// link_path_failover_fsm
// Chooses between direct link, discovery and relay path from a stream of
// link events, with three saturating event counters and programmable limits.
// ----------------------------------------------------------------------------
// An input transfer passes through the input register, then the state update
//   into the result register, before its result is valid.
// Throughput: one event per cycle; a stalled result stalls the input side.
// Reset: asynchronous, active low; path returns to direct, counters clear,
//   all three limits return to 3, both stream stages empty.
module link_path_failover_fsm (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic [lpf_pkg::REG_IDX_W-1:0] cfg_addr_i,
  input  logic [lpf_pkg::CNT_W-1:0]     cfg_wdata_i,
  // Event stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [lpf_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [0] success, [7:1] zero
  input  logic [lpf_pkg::S_TUSER_W-1:0] s_axis_tuser,  // [1:0] command
  // Result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [lpf_pkg::M_TDATA_W-1:0] m_axis_tdata   // [0] error, [2:1] path_state,
                                                       // [7:3] zero
);
  import lpf_pkg::*;

  lpf_cfg_t   cfg;
  lpf_state_t state_q, state_d;
  logic       step_error;

  logic       in_valid_q;
  lpf_cmd_e   in_cmd_q;
  logic       in_success_q;

  logic       out_valid_q;
  logic       out_error_q;
  logic [1:0] out_path_q;

  logic       advance;

  // Policy registers
  lpf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Event update logic
  lpf_step u_step (
    .state_i   (state_q),
    .cfg_i     (cfg),
    .cmd_i     (in_cmd_q),
    .success_i (in_success_q),
    .state_o   (state_d),
    .error_o   (step_error)
  );

  // Result register frees up when empty or being drained
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd_q     <= lpf_cmd_e'(s_axis_tuser);
      in_success_q <= s_axis_tdata[0];
    end
  end

  // Commit the state when the event moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.path            <= PATH_DIRECT;
      state_q.direct_fail_cnt <= '0;
      state_q.relay_fail_cnt  <= '0;
      state_q.recovery_cnt    <= '0;
    end else if (advance && in_valid_q) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      out_error_q <= step_error;
      out_path_q  <= path_encode(state_d.path);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(M_TDATA_W - 3){1'b0}}, out_path_q, out_error_q};

`ifndef SYNTH
  // A waiting result always reports the path currently held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[2:1] == path_encode(state_q.path)))
    else $error("result path differs from held path");

  // Direct failures only count while on the direct path
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.direct_fail_cnt != '0) |-> (state_q.path == PATH_DIRECT))
    else $error("direct failure count set off the direct path");

  // Relay failures only count while the relay is active
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.relay_fail_cnt != '0) |-> (state_q.path == PATH_RELAY))
    else $error("relay failure count set off the relay path");

  // Input side only stalls behind a full, blocked pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a blocked result");
`endif

endmodule
